// ----- rtl/bmp565_pkg.sv -----
// Package: payload types and header constants for the BMP to RGB565 stream converter.
package bmp565_pkg;

  localparam int unsigned SCREEN_WIDTH = 240;
  localparam int unsigned HEADER_BYTES = 54;

  localparam logic [5:0] HDR_IDX_WIDTH    = 6'd18;
  localparam logic [5:0] HDR_IDX_HEIGHT_L = 6'd22;
  localparam logic [5:0] HDR_IDX_HEIGHT_H = 6'd23;
  localparam logic [5:0] HDR_IDX_DEPTH    = 6'd28;
  localparam logic [5:0] HDR_IDX_LAST     = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] HDR_COUNT_END    = 6'(HEADER_BYTES);

  localparam logic [4:0] DEPTH_RGB555 = 5'd2;
  localparam logic [4:0] DEPTH_BGR888 = 5'd3;
  localparam logic [4:0] DEPTH_XRGB   = 5'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bmp565_in_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  screen_column;
    logic [15:0] row_from_bottom;
    logic        last_pixel;
  } bmp565_out_t;

endpackage

// ----- rtl/bmp_stream_to_rgb565.sv -----
// Top level: BMP byte stream parser and RGB565 pixel generator.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (bmp565_in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (bmp565_out_t)
//
// One byte is taken per cycle unless stalled; its pixel, if any, is registered.
// Parsing state and the result are computed in one pass from the accepted byte.
// A single skid entry behind the result register lets one byte through while
// the output is held; in_stall_o rises only when that entry is occupied.
// rst_ni clears all parsing state; the block then parses as at a file start.
module bmp_stream_to_rgb565
  import bmp565_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bmp565_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bmp565_out_t out_data_o
);

  logic [5:0]  hdr_cnt_q,   hdr_cnt_d;
  logic [7:0]  img_w_q,     img_w_d;
  logic [15:0] img_h_q,     img_h_d;
  logic [4:0]  depth_q,     depth_d;
  logic [7:0]  left_off_q,  left_off_d;
  logic [1:0]  phase_q,     phase_d;
  logic [15:0] accum_q,     accum_d;
  logic [7:0]  col_q,       col_d;
  logic [15:0] rows_q,      rows_d;
  logic        done_q,      done_d;

  logic        out_vld_q;
  logic        skid_vld_q;
  bmp565_out_t out_q;
  bmp565_out_t skid_q;

  logic        in_acc;
  logic        out_take;
  logic        res_vld;
  bmp565_out_t res;
  logic        ready;
  logic [8:0]  off_diff;
  logic [7:0]  col_inc;
  logic [15:0] rows_inc;
  logic [7:0]  b;

  assign in_acc      = in_valid_i && !skid_vld_q;
  assign out_take    = out_vld_q && !out_stall_i;
  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.data_byte;

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    img_w_d    = img_w_q;
    img_h_d    = img_h_q;
    depth_d    = depth_q;
    left_off_d = left_off_q;
    phase_d    = phase_q;
    accum_d    = accum_q;
    col_d      = col_q;
    rows_d     = rows_q;
    done_d     = done_q;
    ready      = 1'b0;
    res_vld    = 1'b0;
    res        = '0;
    off_diff   = 9'(SCREEN_WIDTH) - {1'b0, img_w_q};
    col_inc    = 8'd0;
    rows_inc   = 16'd0;

    if (in_data_i.start_of_file) begin
      hdr_cnt_d  = '0;
      img_w_d    = '0;
      img_h_d    = '0;
      depth_d    = '0;
      left_off_d = '0;
      phase_d    = '0;
      accum_d    = '0;
      col_d      = '0;
      rows_d     = '0;
      done_d     = 1'b0;
    end

    if (hdr_cnt_d < HDR_COUNT_END) begin
      if (hdr_cnt_d == HDR_IDX_WIDTH)    img_w_d = b;
      if (hdr_cnt_d == HDR_IDX_HEIGHT_L) img_h_d = {img_h_d[15:8], b};
      if (hdr_cnt_d == HDR_IDX_HEIGHT_H) img_h_d = {b, img_h_d[7:0]};
      if (hdr_cnt_d == HDR_IDX_DEPTH)    depth_d = b[7:3];
      if (hdr_cnt_d == HDR_IDX_LAST) begin
        off_diff = 9'(SCREEN_WIDTH) - {1'b0, img_w_d};
        if ({1'b0, img_w_d} < 9'(SCREEN_WIDTH - 1)) left_off_d = off_diff[8:1];
        else left_off_d = '0;
      end
      hdr_cnt_d = hdr_cnt_d + 6'd1;
    end else if (!done_d) begin
      unique case (depth_d)
        DEPTH_RGB555: begin
          if (phase_d == 2'd0) begin
            accum_d = {7'd0, b[7:5], 1'b0, b[4:0]};
            phase_d = 2'd1;
          end else begin
            accum_d = accum_d + {b[6:0], 9'd0};
            ready   = 1'b1;
          end
        end
        DEPTH_BGR888: begin
          if (phase_d == 2'd0) begin
            accum_d = {11'd0, b[7:3]};
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            accum_d = accum_d + {5'd0, b[7:2], 5'd0};
            phase_d = 2'd2;
          end else begin
            accum_d = accum_d + {b[7:3], 11'd0};
            ready   = 1'b1;
          end
        end
        DEPTH_XRGB: begin
          accum_d = '0;
          if (phase_d == 2'd3) ready = 1'b1;
          else phase_d = phase_d + 2'd1;
        end
        default: ;
      endcase

      if (ready) begin
        res_vld             = 1'b1;
        res.pixel_color     = accum_d;
        res.screen_column   = left_off_d + col_d;
        res.row_from_bottom = rows_d;
        accum_d             = '0;
        phase_d             = '0;
        col_inc             = col_d + 8'd1;
        rows_inc            = rows_d + 16'd1;
        col_d               = col_inc;
        if (col_inc == img_w_d) begin
          col_d  = '0;
          rows_d = rows_inc;
          if (rows_inc == img_h_d) begin
            res.last_pixel = 1'b1;
            done_d         = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= '0;
      img_w_q    <= '0;
      img_h_q    <= '0;
      depth_q    <= '0;
      left_off_q <= '0;
      phase_q    <= '0;
      accum_q    <= '0;
      col_q      <= '0;
      rows_q     <= '0;
      done_q     <= 1'b0;
    end else if (in_acc) begin
      hdr_cnt_q  <= hdr_cnt_d;
      img_w_q    <= img_w_d;
      img_h_q    <= img_h_d;
      depth_q    <= depth_d;
      left_off_q <= left_off_d;
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      col_q      <= col_d;
      rows_q     <= rows_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_acc && res_vld;
      end
    end else if (in_acc && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (in_acc && res_vld) out_q <= res;
    end else if (in_acc && res_vld) begin
      skid_q <= res;
    end
  end

endmodule

// ----- rtl/bmp565_checker.sv -----
// Checker: port-level properties of the BMP to RGB565 converter, bound to the top level.
module bmp565_checker
  import bmp565_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input bmp565_in_t  in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input bmp565_out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o && in_data_i.start_of_file;

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_stall_after_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall raised without a held output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held output transaction changed");

  a_start_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("start byte produced a pixel");

endmodule

bind bmp_stream_to_rgb565 bmp565_checker u_bmp565_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
